@@ rtl/qbmv_pkg.sv @@
// ----------------------------------------------------------------------------
// qbmv_pkg
// Shared types, constants and fp32 helper functions for the block-scaled
// int8 matrix-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qbmv_pkg;

	// default geometry
	localparam int BLOCK_ELEMS_DEF = 32;
	localparam int LANES_DEF       = 8;

	// queue depths
	localparam int BLK_Q_DEPTH = 4;
	localparam int OUT_Q_DEPTH = 2;

	// fixed field widths
	localparam int FP_W    = 32;
	localparam int HALF_W  = 16;
	localparam int CHUNK_W = 64;
	localparam int SIG_W   = 48;
	localparam int EXP_W   = 12;
	localparam int IDX_W   = 2;
	localparam int BPR_W   = 13;
	localparam int ROWS_W  = 17;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ACT_SCALE = 2'd0;
	localparam logic [IDX_W-1:0] REG_BLOCKS    = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROWS      = 2'd2;

	// fixed values
	localparam logic [FP_W-1:0]   FP_ONE    = 32'h3F80_0000;
	localparam logic [FP_W-1:0]   FP_QNAN   = 32'h7FC0_0000;
	localparam logic [BPR_W-1:0]  BPR_MAX   = 13'd4096;
	localparam logic [ROWS_W-1:0] ROWS_MAX  = 17'd65536;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ADD,
		BK_CVT,
		BK_NORM,
		BK_RND,
		BK_FIN
	} bk_state_t;

	typedef enum logic [1:0] {
		SP_NUM,
		SP_INF,
		SP_NAN
	} spec_t;

	// per-block control carried from front to back
	typedef struct packed {
		logic row_end;
		logic last_row;
	} blk_flags_t;

	// one finished row
	typedef struct packed {
		logic [FP_W-1:0] row_sum;
		logic            last_row;
	} row_res_t;

	// unpacked fp32 operand, subnormals carry exponent 1 and no hidden bit
	typedef struct packed {
		logic        s;
		logic [7:0]  e;
		logic [23:0] m;
		logic        nan;
		logic        inf;
		logic        zero;
	} fp_unp_t;

	function automatic fp_unp_t fp_unpack(input logic [FP_W-1:0] b);
		fp_unp_t u;
		u.s    = b[31];
		u.e    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		u.m    = {(b[30:23] != 8'd0), b[22:0]};
		u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		u.zero = (b[30:0] == 31'd0);
		return u;
	endfunction

	// exact fp16 to fp32 widening
	function automatic logic [FP_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		logic [9:0] mm;
		logic [7:0] e32;
		s   = h[15];
		e   = h[14:10];
		m   = h[9:0];
		p   = 4'd0;
		mm  = 10'd0;
		e32 = 8'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i])
				p = 4'(i);
		end
		if (e == 5'd0) begin
			if (m == 10'd0)
				return {s, 31'd0};
			mm  = 10'(m << (4'd10 - p));
			e32 = 8'd103 + 8'(p);
			return {s, e32, mm, 13'd0};
		end
		if (e == 5'd31)
			return {s, 8'hFF, m, 13'd0};
		return {s, 8'(e) + 8'd112, m, 13'd0};
	endfunction

	// leading zero count of the working significand
	function automatic logic [5:0] lzc48(input logic [SIG_W-1:0] v);
		logic [5:0] z;
		z = 6'd48;
		for (int i = 0; i < SIG_W; i++) begin
			if (v[i])
				z = 6'(47 - i);
		end
		return z;
	endfunction

	// round to nearest even; sig has its leading one at bit 47 or is zero,
	// value = sig / 2^47 * 2^(e - 127)
	function automatic logic [FP_W-1:0] fp_round(
		input logic                    s,
		input logic signed [EXP_W-1:0] e,
		input logic [SIG_W-1:0]        sig
	);
		logic [2*SIG_W-1:0]    wide;
		logic [5:0]            sh;
		logic signed [EXP_W-1:0] ee;
		logic [23:0]           kept;
		logic                  g;
		logic                  st;
		logic                  inc;
		logic [24:0]           r;
		logic [7:0]            ef;
		logic [22:0]           fr;
		if (e >= 12'sd1)
			sh = 6'd0;
		else if (e < -12'sd60)
			sh = 6'd63;
		else
			sh = 6'(12'sd1 - e);
		wide = {sig, {SIG_W{1'b0}}} >> sh;
		ee   = (e >= 12'sd1) ? e : 12'sd1;
		kept = wide[95:72];
		g    = wide[71];
		st   = |wide[70:0];
		inc  = g & (st | kept[0]);
		r    = {1'b0, kept} + 25'(inc);
		if (r[24]) begin
			ee = ee + 12'sd1;
			fr = r[23:1];
			ef = 8'(ee);
		end else begin
			fr = r[22:0];
			ef = r[23] ? 8'(ee) : 8'd0;
		end
		if (ee >= 12'sd255)
			return {s, 8'hFF, 23'd0};
		return {s, ef, fr};
	endfunction

endpackage

`default_nettype wire

@@ rtl/qbmv_fifo.sv @@
// ----------------------------------------------------------------------------
// qbmv_fifo
// Small register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module qbmv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/qbmv_front.sv @@
// ----------------------------------------------------------------------------
// qbmv_front
// Takes one chunk per cycle while the queue has room, sums int8 lane products
// into the block dot, tracks block and row position, queues finished blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module qbmv_front #(
	parameter int LANES = 8,
	parameter int CPB   = 4,
	parameter int DOT_W = 21
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [qbmv_pkg::CHUNK_W-1:0]    activation_chunk,
	input  wire logic [qbmv_pkg::CHUNK_W-1:0]    weight_chunk,
	input  wire logic [qbmv_pkg::HALF_W-1:0]     block_scale_half,
	input  wire logic [qbmv_pkg::BPR_W-1:0]      blocks_per_row,
	input  wire logic [qbmv_pkg::ROWS_W-1:0]     row_count,
	output logic                                 rec_push,
	output logic [qbmv_pkg::HALF_W+DOT_W+1:0]    rec_data,
	input  wire logic                            rec_full
);
	import qbmv_pkg::*;

	localparam int CW        = (CPB > 1) ? $clog2(CPB) : 1;
	localparam int ACT_LANES = (LANES > 8) ? 8 : LANES;

	logic [CW-1:0]           chunk_q;
	logic [BPR_W-2:0]        block_q;
	logic [ROWS_W-2:0]       row_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [HALF_W-1:0]       scale_q;

	logic                    accept;
	logic                    first_chunk;
	logic                    last_chunk;
	logic                    row_end;
	logic                    last_row;
	logic signed [DOT_W-1:0] part;
	logic signed [DOT_W-1:0] dot_new;
	logic [HALF_W-1:0]       scale_cur;
	blk_flags_t              flags;

	assign full        = rec_full;
	assign accept      = push & ~rec_full;
	assign first_chunk = (chunk_q == '0);
	assign last_chunk  = (chunk_q == CW'(CPB - 1));
	assign row_end     = ({1'b0, block_q} + BPR_W'(1)) >= blocks_per_row;
	assign last_row    = ({1'b0, row_q} + ROWS_W'(1)) >= row_count;

	// lane products summed for this chunk
	always_comb begin
		part = '0;
		for (int i = 0; i < ACT_LANES; i++) begin
			part = part + DOT_W'($signed(activation_chunk[8*i +: 8]) *
				$signed(weight_chunk[8*i +: 8]));
		end
	end

	assign dot_new   = (first_chunk ? '0 : dot_q) + part;
	assign scale_cur = first_chunk ? block_scale_half : scale_q;

	// block record to the back end
	assign flags.row_end  = row_end;
	assign flags.last_row = last_row;
	assign rec_push       = accept & last_chunk;
	assign rec_data       = {scale_cur, dot_new, flags};

	// partial block dot and held scale
	always_ff @(posedge clk) begin
		if (accept) begin
			dot_q   <= dot_new;
			scale_q <= scale_cur;
		end
	end

	// chunk, block and row position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			block_q <= '0;
			row_q   <= '0;
		end else if (accept) begin
			chunk_q <= last_chunk ? '0 : chunk_q + CW'(1);
			if (last_chunk) begin
				block_q <= row_end ? '0 : block_q + 12'd1;
				if (row_end)
					row_q <= last_row ? '0 : row_q + 16'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/qbmv_back.sv @@
// ----------------------------------------------------------------------------
// qbmv_back
// Per-block fp32 sequence: scale product, dot conversion, term product and
// row accumulation, through one shared multiply/add, normalize and round
// path. Emits the row value at each row end.
// ----------------------------------------------------------------------------
`default_nettype none

module qbmv_back #(
	parameter int DOT_W = 21
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rec_empty,
	output logic                               rec_pop,
	input  wire logic [qbmv_pkg::HALF_W+DOT_W+1:0] rec_data,
	input  wire logic [qbmv_pkg::FP_W-1:0]     act_scale,
	input  wire logic                          out_full,
	output logic                               out_push,
	output qbmv_pkg::row_res_t                 out_data
);
	import qbmv_pkg::*;

	bk_state_t               state_q;
	bk_state_t               state_d;
	logic [1:0]              phase_q;
	blk_flags_t              flags_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [FP_W-1:0]         op_a_q;
	logic [FP_W-1:0]         op_b_q;
	logic                    sign_q;
	logic signed [EXP_W-1:0] exp_q;
	logic [SIG_W-1:0]        sig_q;
	spec_t                   spec_q;
	logic [FP_W-1:0]         acc_q;

	// record fields
	logic [HALF_W-1:0]       rec_scale;
	logic signed [DOT_W-1:0] rec_dot;
	blk_flags_t              rec_flags;

	// datapath terms
	fp_unp_t                 ua;
	fp_unp_t                 ub;
	logic                    mul_sign;
	logic signed [EXP_W-1:0] mul_exp;
	logic [SIG_W-1:0]        mul_sig;
	spec_t                   mul_spec;
	fp_unp_t                 big;
	fp_unp_t                 sml;
	logic [7:0]              ediff;
	logic [53:0]             al_wide;
	logic [26:0]             al_sml;
	logic [27:0]             add_sum;
	logic                    add_sign;
	spec_t                   add_spec;
	logic [DOT_W-1:0]        dot_mag;
	logic [5:0]              lz;
	logic [FP_W-1:0]         rnd_res;

	assign {rec_scale, rec_dot, rec_flags} = rec_data;

	// multiply step
	always_comb begin
		ua       = fp_unpack(op_a_q);
		ub       = fp_unpack(op_b_q);
		mul_sign = ua.s ^ ub.s;
		mul_sig  = ua.m * ub.m;
		mul_exp  = $signed({4'd0, ua.e}) + $signed({4'd0, ub.e}) - 12'sd126;
		if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero))
			mul_spec = SP_NAN;
		else if (ua.inf || ub.inf)
			mul_spec = SP_INF;
		else
			mul_spec = SP_NUM;
	end

	// add step: align the smaller operand, keep guard, round and sticky
	always_comb begin
		if ({ua.e, ua.m} >= {ub.e, ub.m}) begin
			big = ua;
			sml = ub;
		end else begin
			big = ub;
			sml = ua;
		end
		ediff   = big.e - sml.e;
		al_wide = {sml.m, 3'd0, 27'd0} >> ediff;
		if (ediff >= 8'd27)
			al_sml = {26'd0, |sml.m};
		else
			al_sml = {al_wide[53:28], al_wide[27] | (|al_wide[26:0])};
		if (big.s == sml.s)
			add_sum = {1'b0, big.m, 3'd0} + {1'b0, al_sml};
		else
			add_sum = {1'b0, big.m, 3'd0} - {1'b0, al_sml};
		add_sign = (add_sum == 28'd0) ? (ua.s & ub.s) : big.s;
		if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.s != ub.s)))
			add_spec = SP_NAN;
		else if (ua.inf || ub.inf)
			add_spec = SP_INF;
		else
			add_spec = SP_NUM;
	end

	// conversion, normalize and round terms
	assign dot_mag = rec_dot_sel(dot_q);
	assign lz      = lzc48(sig_q);

	function automatic logic [DOT_W-1:0] rec_dot_sel(input logic signed [DOT_W-1:0] d);
		return d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
	endfunction

	always_comb begin
		unique case (spec_q)
			SP_NAN:  rnd_res = FP_QNAN;
			SP_INF:  rnd_res = {sign_q, 8'hFF, 23'd0};
			default: rnd_res = fp_round(sign_q, exp_q, sig_q);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!rec_empty) state_d = BK_MUL;
			BK_MUL:  state_d = BK_NORM;
			BK_ADD:  state_d = BK_NORM;
			BK_CVT:  state_d = BK_NORM;
			BK_NORM: state_d = BK_RND;
			BK_RND: begin
				case (phase_q)
					2'd0:    state_d = BK_CVT;
					2'd1:    state_d = BK_MUL;
					2'd2:    state_d = BK_ADD;
					default: state_d = flags_q.row_end ? BK_FIN : BK_IDLE;
				endcase
			end
			BK_FIN:  if (!out_full) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		rec_pop  = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			BK_IDLE: rec_pop  = ~rec_empty;
			BK_FIN:  out_push = ~out_full;
			default: ;
		endcase
	end

	assign out_data.row_sum  = acc_q;
	assign out_data.last_row = flags_q.last_row;

	// control state and row accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			phase_q <= 2'd0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE)
				phase_q <= 2'd0;
			else if (state_q == BK_RND)
				phase_q <= phase_q + 2'd1;
			if (state_q == BK_RND && phase_q == 2'd3)
				acc_q <= rnd_res;
			else if (out_push)
				acc_q <= '0;
		end
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (!rec_empty) begin
					flags_q <= rec_flags;
					dot_q   <= rec_dot;
					op_a_q  <= half_to_single(rec_scale);
					op_b_q  <= act_scale;
				end
			end
			BK_MUL: begin
				sign_q <= mul_sign;
				exp_q  <= mul_exp;
				sig_q  <= mul_sig;
				spec_q <= mul_spec;
			end
			BK_ADD: begin
				sign_q <= add_sign;
				exp_q  <= $signed({4'd0, big.e}) + 12'sd1;
				sig_q  <= {add_sum, 20'd0};
				spec_q <= add_spec;
			end
			BK_CVT: begin
				sign_q <= dot_q[DOT_W-1];
				exp_q  <= $signed(EXP_W'(126 + DOT_W));
				sig_q  <= {dot_mag, {(SIG_W - DOT_W){1'b0}}};
				spec_q <= SP_NUM;
			end
			BK_NORM: begin
				// a zero significand gets the smallest exponent
				if (sig_q == '0) begin
					exp_q <= 12'sd0;
				end else begin
					exp_q <= exp_q - $signed({6'd0, lz});
					sig_q <= sig_q << lz;
				end
			end
			BK_RND: begin
				case (phase_q)
					2'd0: op_a_q <= rnd_res;
					2'd1: op_b_q <= rnd_res;
					2'd2: begin
						op_a_q <= acc_q;
						op_b_q <= rnd_res;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/q8_block_scaled_int8_matvec.sv @@
// ----------------------------------------------------------------------------
// q8_block_scaled_int8_matvec
// Block-scaled int8 matrix-vector unit: int8 chunk dots per block, fp32 row
// accumulation, one result per row.
// ----------------------------------------------------------------------------
// The front end takes one chunk every cycle while the block queue has room
// and sums its lane products into the integer block dot; each finished block
// goes into a four-entry queue. The back end works one block at a time
// through a shared fp32 multiply/add, normalize and round path, and takes no
// new block before it is through with the last one; when a block closes a
// row, the row value is pushed to the two-entry result queue. In a long
// stream the back end therefore sets the pace of the chunks, and a full
// queue holds them back. Any NaN row value comes out as 0x7FC00000.
// Configuration is written through the cfg port, which is always ready;
// write it only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module q8_block_scaled_int8_matvec #(
	parameter int BLOCK_ELEMS = qbmv_pkg::BLOCK_ELEMS_DEF,
	parameter int LANES       = qbmv_pkg::LANES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [qbmv_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [qbmv_pkg::FP_W-1:0]    cfg_data,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [qbmv_pkg::CHUNK_W-1:0] activation_chunk,
	input  wire logic [qbmv_pkg::CHUNK_W-1:0] weight_chunk,
	input  wire logic [qbmv_pkg::HALF_W-1:0]  block_scale_half,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [qbmv_pkg::FP_W-1:0]         row_sum,
	output logic                              last_row
);
	import qbmv_pkg::*;

	localparam int CPB       = (BLOCK_ELEMS / LANES == 0) ? 1 : BLOCK_ELEMS / LANES;
	localparam int ACT_LANES = (LANES > 8) ? 8 : LANES;
	localparam int DOT_W     = $clog2(CPB * ACT_LANES * 16384 + 1) + 1;
	localparam int REC_W     = HALF_W + DOT_W + 2;

	logic [FP_W-1:0]   act_scale_q;
	logic [BPR_W-1:0]  bpr_q;
	logic [ROWS_W-1:0] rows_q;
	logic [BPR_W-1:0]  bpr_in;
	logic [ROWS_W-1:0] rows_in;
	logic              cfg_we;

	logic              rec_push;
	logic              rec_pop;
	logic              rec_full;
	logic              rec_empty;
	logic [REC_W-1:0]  rec_wdata;
	logic [REC_W-1:0]  rec_rdata;

	logic              out_push;
	logic              out_full;
	row_res_t          out_wdata;
	row_res_t          out_rdata;

	// configuration registers, counts clamped on write
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign bpr_in    = cfg_data[BPR_W-1:0];
	assign rows_in   = cfg_data[ROWS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_scale_q <= FP_ONE;
			bpr_q       <= BPR_W'(1);
			rows_q      <= ROWS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACT_SCALE: act_scale_q <= cfg_data;
				REG_BLOCKS: begin
					if (bpr_in == '0)
						bpr_q <= BPR_W'(1);
					else if (bpr_in > BPR_MAX)
						bpr_q <= BPR_MAX;
					else
						bpr_q <= bpr_in;
				end
				REG_ROWS: begin
					if (rows_in == '0)
						rows_q <= ROWS_W'(1);
					else if (rows_in > ROWS_MAX)
						rows_q <= ROWS_MAX;
					else
						rows_q <= rows_in;
				end
				default: ;
			endcase
		end
	end

	qbmv_front #(
		.LANES (LANES),
		.CPB   (CPB),
		.DOT_W (DOT_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.activation_chunk (activation_chunk),
		.weight_chunk     (weight_chunk),
		.block_scale_half (block_scale_half),
		.blocks_per_row   (bpr_q),
		.row_count        (rows_q),
		.rec_push         (rec_push),
		.rec_data         (rec_wdata),
		.rec_full         (rec_full)
	);

	qbmv_fifo #(
		.WIDTH (REC_W),
		.DEPTH (BLK_Q_DEPTH)
	) u_blk_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_wdata),
		.full   (rec_full),
		.pop    (rec_pop),
		.rdata  (rec_rdata),
		.empty  (rec_empty)
	);

	qbmv_back #(
		.DOT_W (DOT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (rec_empty),
		.rec_pop   (rec_pop),
		.rec_data  (rec_rdata),
		.act_scale (act_scale_q),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_wdata)
	);

	qbmv_fifo #(
		.WIDTH ($bits(row_res_t)),
		.DEPTH (OUT_Q_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign row_sum  = out_rdata.row_sum;
	assign last_row = out_rdata.last_row;

	// block records only enter a queue with room
	assert property (@(posedge clk) disable iff (!arst_n) rec_push |-> !rec_full)
		else $error("block record pushed into full queue");

	// row values only enter a queue with room
	assert property (@(posedge clk) disable iff (!arst_n) out_push |-> !out_full)
		else $error("row value pushed into full result queue");

	// a block record is taken only when the back end is free and one waits
	assert property (@(posedge clk) disable iff (!arst_n) rec_pop |-> !rec_empty)
		else $error("block record taken from empty queue");

endmodule

`default_nettype wire
